[rtl/core/psmc_pkg.sv]
// ----------------------------------------------------------------------------
// psmc_pkg
// Shared types and constants for the pedal sample median conditioner.
// ----------------------------------------------------------------------------
package psmc_pkg;

  localparam int unsigned SAMPLE_W     = 12;
  localparam int unsigned GAIN_W       = 8;
  localparam int unsigned VAL_W        = 7;
  localparam int unsigned PROD_W       = SAMPLE_W + GAIN_W;
  localparam int unsigned BIT_W        = $clog2(VAL_W);

  localparam int unsigned RING_DEPTH   = 32;
  localparam int unsigned RING_AW      = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W        = $clog2(RING_DEPTH + 1);
  localparam int unsigned HALF         = RING_DEPTH / 2;
  localparam int unsigned RANK_LO      = RING_DEPTH - 1 - HALF;
  localparam int unsigned RANK_HI      = HALF;

  localparam int unsigned CHANGE_LIMIT = 100;
  localparam int unsigned CHG_W        = $clog2(CHANGE_LIMIT + 1);

  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 12;

  localparam logic [VAL_W-1:0] VAL_MAX = VAL_W'(127);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET    = 2'd0,
    REG_GAIN      = 2'd1,
    REG_INVERT    = 2'd2,
    REG_REPORT_EN = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] value;
  } med_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] median;
  } med_stat_t;

endpackage

[rtl/core/psmc_cond.sv]
// ----------------------------------------------------------------------------
// psmc_cond
// Offset removal, gain, saturation and optional inversion of one sample.
// ----------------------------------------------------------------------------
module psmc_cond
  import psmc_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [SAMPLE_W-1:0] offset_i,
  input  logic [GAIN_W-1:0]   gain_i,
  input  logic                invert_i,
  output logic [VAL_W-1:0]    value_o
);

  logic [SAMPLE_W-1:0] diff;
  logic [PROD_W-1:0]   prod;
  logic [VAL_W-1:0]    sat;
  logic [VAL_W-1:0]    value_d;
  logic [VAL_W-1:0]    value_q;

  always_comb begin
    diff    = (sample_i > offset_i) ? (sample_i - offset_i) : '0;
    prod    = PROD_W'(diff) * PROD_W'(gain_i);
    sat     = (prod > PROD_W'(VAL_MAX)) ? VAL_MAX : prod[VAL_W-1:0];
    value_d = invert_i ? (VAL_MAX - sat) : sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

[rtl/core/psmc_median.sv]
// ----------------------------------------------------------------------------
// psmc_median
// Sample ring and median search: a bit-serial rank select for the two middle
// order statistics, then a scan for the first ring entry between them.
// ----------------------------------------------------------------------------
module psmc_median
  import psmc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  med_ctrl_t ctrl_i,
  output med_stat_t stat_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SCAN
  } state_e;

  state_e             state_q;
  logic [VAL_W-1:0]   ring_q [RING_DEPTH];
  logic [RING_AW-1:0] slot_q;
  logic [RING_AW-1:0] idx_q;
  logic [BIT_W-1:0]   bit_q;
  logic [VAL_W-1:0]   pfx_lo_q;
  logic [VAL_W-1:0]   pfx_hi_q;
  logic [CNT_W-1:0]   rank_lo_q;
  logic [CNT_W-1:0]   rank_hi_q;
  logic [CNT_W-1:0]   cnt_lo_q;
  logic [CNT_W-1:0]   cnt_hi_q;
  logic               done_q;
  logic [VAL_W-1:0]   median_q;

  logic [VAL_W-1:0]   elem;
  logic [VAL_W-1:0]   bit_oh;
  logic [VAL_W-1:0]   up_mask;
  logic               match_lo;
  logic               match_hi;
  logic [CNT_W-1:0]   tot_lo;
  logic [CNT_W-1:0]   tot_hi;
  logic               in_range;
  logic               last_idx;

  always_comb begin
    elem     = ring_q[idx_q];
    bit_oh   = VAL_W'(1) << bit_q;
    up_mask  = ~((bit_oh << 1) - VAL_W'(1));
    match_lo = ((elem & up_mask) == (pfx_lo_q & up_mask)) && !elem[bit_q];
    match_hi = ((elem & up_mask) == (pfx_hi_q & up_mask)) && !elem[bit_q];
    tot_lo   = cnt_lo_q + CNT_W'(match_lo);
    tot_hi   = cnt_hi_q + CNT_W'(match_hi);
    in_range = (elem >= pfx_lo_q) && (elem <= pfx_hi_q);
    last_idx = (idx_q == RING_AW'(RING_DEPTH - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      slot_q    <= '0;
      idx_q     <= '0;
      bit_q     <= '0;
      pfx_lo_q  <= '0;
      pfx_hi_q  <= '0;
      rank_lo_q <= '0;
      rank_hi_q <= '0;
      cnt_lo_q  <= '0;
      cnt_hi_q  <= '0;
      done_q    <= 1'b0;
      median_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (ctrl_i.start) begin
            ring_q[slot_q] <= ctrl_i.value;
            slot_q    <= (slot_q == RING_AW'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
            idx_q     <= '0;
            bit_q     <= BIT_W'(VAL_W - 1);
            pfx_lo_q  <= '0;
            pfx_hi_q  <= '0;
            rank_lo_q <= CNT_W'(RANK_LO);
            rank_hi_q <= CNT_W'(RANK_HI);
            cnt_lo_q  <= '0;
            cnt_hi_q  <= '0;
            state_q   <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          if (last_idx) begin
            if (rank_lo_q >= tot_lo) begin
              pfx_lo_q  <= pfx_lo_q | bit_oh;
              rank_lo_q <= rank_lo_q - tot_lo;
            end
            if (rank_hi_q >= tot_hi) begin
              pfx_hi_q  <= pfx_hi_q | bit_oh;
              rank_hi_q <= rank_hi_q - tot_hi;
            end
            cnt_lo_q <= '0;
            cnt_hi_q <= '0;
            idx_q    <= '0;
            if (bit_q == '0) begin
              state_q <= ST_SCAN;
            end else begin
              bit_q <= bit_q - 1'b1;
            end
          end else begin
            cnt_lo_q <= tot_lo;
            cnt_hi_q <= tot_hi;
            idx_q    <= idx_q + 1'b1;
          end
        end
        ST_SCAN: begin
          if (in_range || last_idx) begin
            median_q <= in_range ? elem : '0;
            done_q   <= 1'b1;
            state_q  <= ST_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat_o.done   = done_q;
  assign stat_o.median = median_q;

endmodule

[rtl/core/pedal_sample_median_conditioner_unit.sv]
// ----------------------------------------------------------------------------
// pedal_sample_median_conditioner_unit
// Conditions pedal converter samples, filters them with a 32-entry running
// median and flags decimated changes of the filtered value.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   sample_i
//   out      source     out_valid_o / out_ready_i filtered_o, report_o
//   cfg      sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// After acceptance a transaction passes through conditioning, seven counting
// passes over the ring, one per value bit, for both middle ranks together,
// a scan that stops at the first entry between the two middle ranks, and
// the handoff to the output register. The input is ready again in the cycle
// after the result is loaded.
// Reset clears the ring, history, counter and control registers at once; the conditioned-sample register has no reset.
// The input is taken again while a finished result waits on out; a result
// stalls in the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module pedal_sample_median_conditioner_unit
  import psmc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VAL_W-1:0]      filtered_o,
  output logic                  report_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COND,
    ST_START,
    ST_WAIT,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic [SAMPLE_W-1:0] offset_q;
  logic [GAIN_W-1:0]  gain_q;
  logic               invert_q;
  logic               report_en_q;
  logic [VAL_W-1:0]   hist0_q;
  logic [VAL_W-1:0]   hist1_q;
  logic [CHG_W-1:0]   chg_cnt_q;
  logic [VAL_W-1:0]   res_val_q;
  logic               res_rep_q;
  logic               out_valid_q;
  logic [VAL_W-1:0]   out_val_q;
  logic               out_rep_q;

  logic               in_acc;
  logic [VAL_W-1:0]   cond_val;
  med_ctrl_t          med_ctrl;
  med_stat_t          med_stat;
  logic               qualify;
  logic               at_limit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  psmc_cond u_cond (
    .clk_i    (clk_i),
    .en_i     (in_acc),
    .sample_i (sample_i),
    .offset_i (offset_q),
    .gain_i   (gain_q),
    .invert_i (invert_q),
    .value_o  (cond_val)
  );

  assign med_ctrl.start = (state_q == ST_START);
  assign med_ctrl.value = cond_val;

  psmc_median u_median (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (med_ctrl),
    .stat_o (med_stat)
  );

  assign qualify  = report_en_q && (med_stat.median != hist0_q)
                    && (med_stat.median != hist1_q);
  assign at_limit = (chg_cnt_q == CHG_W'(CHANGE_LIMIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      gain_q      <= GAIN_W'(1);
      invert_q    <= 1'b0;
      report_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OFFSET:    offset_q    <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_GAIN:      gain_q      <= cfg_wdata_i[GAIN_W-1:0];
        REG_INVERT:    invert_q    <= cfg_wdata_i[0];
        REG_REPORT_EN: report_en_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hist0_q     <= '0;
      hist1_q     <= '0;
      chg_cnt_q   <= '0;
      res_val_q   <= '0;
      res_rep_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_rep_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_COND;
          end
        end
        ST_COND: begin
          state_q <= ST_START;
        end
        ST_START: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (med_stat.done) begin
            res_val_q <= med_stat.median;
            res_rep_q <= qualify && at_limit;
            if (qualify) begin
              if (at_limit) begin
                chg_cnt_q <= '0;
                hist1_q   <= hist0_q;
                hist0_q   <= med_stat.median;
              end else begin
                chg_cnt_q <= chg_cnt_q + 1'b1;
              end
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_rep_q   <= res_rep_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_val_q;
  assign report_o    = out_rep_q;

  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    med_stat.done |-> (state_q == ST_WAIT))
    else $error("median done outside wait state");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chg_cnt_q <= CHG_W'(CHANGE_LIMIT))
    else $error("change counter beyond limit");

  a_busy_after_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input ready while transaction in flight");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pedal sample median conditioner. A directed
// table covers the reset state, the field extremes, saturation, inversion and
// every register. Random phases follow, each with a fresh register setting.
// Most samples follow a slowly drifting pedal level, so the median wanders
// and the change counter reaches its report point; the rest are noise and
// rail values. Every result is checked against its pinned value or against
// an in-bench model of the conditioning, the 32-entry median ring and the change reporting.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psmc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_500_000;
  localparam int unsigned HOLD_AT      = 250;
  localparam int unsigned HOLD_CYCLES  = 2500;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 75;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic [VAL_W-1:0] filtered;
    logic             report;
  } pedal_out_t;

  typedef struct packed {
    bit                    is_cfg;
    cfg_reg_e              idx;
    logic [SAMPLE_W-1:0]   data;
    bit                    pin;
    logic [VAL_W-1:0]      filt;
  } dir_row_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   sample    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VAL_W-1:0]      filtered;
  logic                  report;
  logic                  cfg_we    = 1'b0;
  cfg_reg_e              cfg_idx   = REG_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // pinned expectation that travels with the sample being offered
  bit                    pin_en    = 1'b0;
  logic [VAL_W-1:0]      pin_filt  = '0;
  logic                  pin_rep   = 1'b0;

  bit                    burst_mode = 1'b0;
  bit                    hold_done  = 1'b0;
  int unsigned           cycles, err_cnt, results_seen, reports_seen;
  int unsigned           items_sent, reg_writes;

  pedal_out_t            pending_medians[$];

  // conditioner model state
  logic [SAMPLE_W-1:0]   m_offset;
  logic [GAIN_W-1:0]     m_gain;
  logic                  m_invert;
  logic                  m_rep_en;
  logic [VAL_W-1:0]      level_ring[RING_DEPTH];
  logic [RING_AW-1:0]    ring_wr;
  logic [VAL_W-1:0]      sent_hist[2];
  int unsigned           chg_cnt;

  pedal_sample_median_conditioner_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .filtered_o  (filtered),
    .report_o    (report),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [VAL_W-1:0] scale_sample(logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] diff;
    logic [PROD_W-1:0]   prod;
    logic [VAL_W-1:0]    v;
    diff = (s > m_offset) ? s - m_offset : '0;
    prod = PROD_W'(diff) * PROD_W'(m_gain);
    v = (prod > PROD_W'(VAL_MAX)) ? VAL_MAX : prod[VAL_W-1:0];
    return m_invert ? VAL_MAX - v : v;
  endfunction

  function automatic logic [VAL_W-1:0] ring_median();
    int unsigned lt, gt;
    for (int i = 0; i < RING_DEPTH; i++) begin
      lt = 0;
      gt = 0;
      for (int j = 0; j < RING_DEPTH; j++) begin
        if (level_ring[j] < level_ring[i]) lt++;
        else if (level_ring[j] > level_ring[i]) gt++;
      end
      if (lt <= HALF && gt <= HALF) return level_ring[i];
    end
    return '0;
  endfunction

  function automatic pedal_out_t predict_pedal_result(logic [SAMPLE_W-1:0] s);
    pedal_out_t r;
    level_ring[ring_wr] = scale_sample(s);
    ring_wr = ring_wr + 1'b1;
    r.filtered = ring_median();
    r.report = 1'b0;
    if (m_rep_en && r.filtered != sent_hist[0] && r.filtered != sent_hist[1]) begin
      if (chg_cnt == CHANGE_LIMIT) begin
        chg_cnt = 0;
        r.report = 1'b1;
        sent_hist[1] = sent_hist[0];
        sent_hist[0] = r.filtered;
      end else begin
        chg_cnt++;
      end
    end
    return r;
  endfunction

  function automatic dir_row_t mk_item(logic [SAMPLE_W-1:0] s, bit pin,
                                       logic [VAL_W-1:0] f);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = REG_OFFSET;
    row.data   = s;
    row.pin    = pin;
    row.filt   = f;
    return row;
  endfunction

  function automatic dir_row_t mk_cfg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    dir_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = d;
    row.pin    = 1'b0;
    row.filt   = '0;
    return row;
  endfunction

  task automatic push_sample(logic [SAMPLE_W-1:0] s, bit pin, logic [VAL_W-1:0] f);
    while (!burst_mode && $urandom_range(0, 99) < 29) @(negedge clk_i);
    in_valid = 1'b1;
    sample   = s;
    pin_en   = pin;
    pin_filt = f;
    pin_rep  = 1'b0;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    in_valid = 1'b0;
    items_sent++;
  endtask

  task automatic set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    while (pending_medians.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = d;
    @(negedge clk_i);
    cfg_we = 1'b0;
    reg_writes++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: watchdog expired after %0d cycles", $time, cycles);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off to back up the block
  always begin
    @(negedge clk_i);
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      out_ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
    end
    out_ready = burst_mode || ($urandom_range(0, 99) >= 29);
  end

  always @(posedge clk_i) begin
    pedal_out_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (report) reports_seen++;
        if (pending_medians.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transaction, filtered %0d report %0d",
                   $time, filtered, report);
        end else begin
          want = pending_medians.pop_front();
          if (filtered !== want.filtered) begin
            err_cnt++;
            $display("%0t: filtered mismatch, expected %0d actual %0d",
                     $time, want.filtered, filtered);
          end
          if (report !== want.report) begin
            err_cnt++;
            $display("%0t: report mismatch, expected %0d actual %0d",
                     $time, want.report, report);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = predict_pedal_result(sample);
        if (pin_en) begin
          want.filtered = pin_filt;
          want.report   = pin_rep;
        end
        pending_medians.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_OFFSET:    m_offset = cfg_wdata[SAMPLE_W-1:0];
          REG_GAIN:      m_gain   = cfg_wdata[GAIN_W-1:0];
          REG_INVERT:    m_invert = cfg_wdata[0];
          REG_REPORT_EN: m_rep_en = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  initial begin
    dir_row_t            rows[$];
    int                  level, lo, hi, span, step, pick;
    logic [SAMPLE_W-1:0] s, off;
    logic [GAIN_W-1:0]   g;
    logic                inv;

    m_offset = '0;
    m_gain   = GAIN_W'(1);
    m_invert = 1'b0;
    m_rep_en = 1'b0;
    foreach (level_ring[i]) level_ring[i] = '0;
    ring_wr      = '0;
    sent_hist[0] = '0;
    sent_hist[1] = '0;
    chg_cnt      = 0;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // fewer than half the ring is filled, so the median stays at zero
    rows.push_back(mk_item(12'h000, 1'b1, '0));
    rows.push_back(mk_item(12'hFFF, 1'b1, '0));
    rows.push_back(mk_item(12'h001, 1'b1, '0));
    rows.push_back(mk_item(12'h800, 1'b1, '0));
    rows.push_back(mk_item(12'hAAA, 1'b1, '0));
    rows.push_back(mk_item(12'h555, 1'b1, '0));
    rows.push_back(mk_item(12'h07F, 1'b1, '0));
    rows.push_back(mk_item(12'h080, 1'b1, '0));
    rows.push_back(mk_item(12'hFFE, 1'b1, '0));
    rows.push_back(mk_item(12'h7FF, 1'b1, '0));
    rows.push_back(mk_item(12'h0F0, 1'b1, '0));
    rows.push_back(mk_item(12'hF0F, 1'b1, '0));
    rows.push_back(mk_item(12'h3C3, 1'b1, '0));
    rows.push_back(mk_item(12'hC3C, 1'b1, '0));
    rows.push_back(mk_item(12'h010, 1'b1, '0));
    // full gain: saturate, never wrap
    rows.push_back(mk_cfg(REG_GAIN, 12'hAFF));
    rows.push_back(mk_item(12'hFFF, 1'b0, '0));
    rows.push_back(mk_item(12'h001, 1'b0, '0));
    rows.push_back(mk_item(12'h000, 1'b0, '0));
    rows.push_back(mk_item(12'hFFF, 1'b0, '0));
    rows.push_back(mk_item(12'h07F, 1'b0, '0));
    // full offset, zero gain, mirrored, reporting on
    rows.push_back(mk_cfg(REG_OFFSET, 12'hFFF));
    rows.push_back(mk_cfg(REG_INVERT, 12'hFFF));
    rows.push_back(mk_cfg(REG_REPORT_EN, 12'h001));
    rows.push_back(mk_cfg(REG_GAIN, 12'h000));
    rows.push_back(mk_item(12'hFFF, 1'b0, '0));
    rows.push_back(mk_item(12'h000, 1'b0, '0));
    rows.push_back(mk_item(12'h123, 1'b0, '0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) set_reg(rows[i].idx, rows[i].data);
      else push_sample(rows[i].data, rows[i].pin, rows[i].filt);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      off = (ph == 0) ? 12'd0 : (ph == 1) ? 12'd4095 : 12'($urandom_range(0, 3900));
      g   = (ph == 0) ? 8'd255 : (ph == 1) ? 8'd0 : (ph == 2) ? 8'd1 :
            8'($urandom_range(1, 12));
      inv = 1'($urandom_range(0, 1));
      set_reg(REG_OFFSET, off);
      set_reg(REG_GAIN, {4'($urandom_range(0, 15)), g});
      set_reg(REG_INVERT, {11'($urandom_range(0, 2047)), inv});
      set_reg(REG_REPORT_EN, {11'($urandom_range(0, 2047)), 1'(ph != 4)});

      burst_mode = (ph == 6);
      span  = (g == 0) ? 256 : 160 / int'(g) + 16;
      step  = span / 8 + 1;
      lo    = (int'(off) - span / 4 < 0) ? 0 : int'(off) - span / 4;
      hi    = (int'(off) + span > 4095) ? 4095 : int'(off) + span;
      level = (lo + hi) / 2;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          level = level + int'($urandom_range(0, 2 * step)) - step;
          if (level < lo) level = lo;
          if (level > hi) level = hi;
          s = 12'(level);
        end else if (pick < 92) begin
          s = 12'($urandom_range(0, 4095));
        end else begin
          s = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        end
        push_sample(s, 1'b0, '0);
      end
      burst_mode = 1'b0;
    end

    while (pending_medians.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run covered %0d samples, %0d register writes, %0d results checked",
             items_sent, reg_writes, results_seen);
    $display("change reports seen: %0d, mismatches: %0d", reports_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
